>>> rtl/kdcl_pkg.sv
// Shared types and constants for the kd-tree cell locate block.
package kdcl_pkg;

   localparam int COORD_W   = 32;
   localparam int DIM_W     = 3;
   localparam int COUNT_W   = 11;
   localparam int NADDR_W   = 10;
   localparam int ACTION_W  = 2;
   localparam int DIM_SLOTS = 4;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = COUNT_W;
   localparam int NODE_DATA_W = DIM_W + COORD_W + COUNT_W;

   localparam logic [DIM_W-1:0]   DIMS_USED_RESET   = 3'd2;
   localparam logic [COUNT_W-1:0] POINT_COUNT_RESET = 11'd1;

   typedef enum logic [ACTION_W-1:0] {
      ACT_LOAD_NODE   = 2'd0,
      ACT_LOAD_BOUNDS = 2'd1,
      ACT_LOCATE_PT   = 2'd2,
      ACT_LOCATE_IDX  = 2'd3
   } action_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DIMS_USED   = 1'd0,
      CSR_POINT_COUNT = 1'd1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE    = 2'd0,
      ST_DESCEND = 2'd1,
      ST_DONE    = 2'd2
   } state_type;

   typedef struct packed {
      logic load_node;
      logic load_bounds;
      logic start;
      logic step;
   } cmd_type;

   typedef struct packed {
      logic done;
   } status_type;

endpackage

>>> rtl/kdcl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module kdcl_ram #(
   parameter int WIDTH = 46,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/kdcl_ctrl.sv
// Controller: sequences loads, the descent and result delivery.
module kdcl_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  kdcl_pkg::action_type     req_action,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output kdcl_pkg::cmd_type        cmd,
   input  kdcl_pkg::status_type     status
);

   kdcl_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         kdcl_pkg::ST_IDLE: begin
            if (req_valid && (req_action == kdcl_pkg::ACT_LOCATE_PT ||
                              req_action == kdcl_pkg::ACT_LOCATE_IDX)) begin
               state_in = kdcl_pkg::ST_DESCEND;
            end
         end
         kdcl_pkg::ST_DESCEND: begin
            if (status.done) begin
               state_in = kdcl_pkg::ST_DONE;
            end
         end
         kdcl_pkg::ST_DONE: begin
            if (rsp_ready) begin
               state_in = kdcl_pkg::ST_IDLE;
            end
         end
         default: state_in = kdcl_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      cmd       = '0;
      case (state_ff)
         kdcl_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (req_action)
                  kdcl_pkg::ACT_LOAD_NODE:   cmd.load_node   = 1'b1;
                  kdcl_pkg::ACT_LOAD_BOUNDS: cmd.load_bounds = 1'b1;
                  default:                   cmd.start       = 1'b1;
               endcase
            end
         end
         kdcl_pkg::ST_DESCEND: cmd.step  = 1'b1;
         kdcl_pkg::ST_DONE:    rsp_valid = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kdcl_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> rtl/kdcl_dpath.sv
// Datapath: node table, root box, configuration and descent registers.
module kdcl_dpath #(
   parameter int MAX_POINTS = 1024,
   parameter int MAX_DIMS   = 4
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  kdcl_pkg::cmd_type                     cmd,
   output kdcl_pkg::status_type                  status,
   input  logic                                  csr_we,
   input  kdcl_pkg::csr_index_type               csr_index,
   input  logic [kdcl_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  kdcl_pkg::action_type                  action,
   input  logic [kdcl_pkg::NADDR_W-1:0]          node_addr,
   input  logic [kdcl_pkg::DIM_W-1:0]            split_dim,
   input  logic signed [kdcl_pkg::COORD_W-1:0]   split_value,
   input  logic [kdcl_pkg::COUNT_W-1:0]          left_count,
   input  logic signed [kdcl_pkg::COORD_W-1:0]   bound_low,
   input  logic signed [kdcl_pkg::COORD_W-1:0]   bound_high,
   input  logic signed [kdcl_pkg::COORD_W-1:0]   query [kdcl_pkg::DIM_SLOTS],
   input  logic [kdcl_pkg::NADDR_W-1:0]          query_index,
   output logic [kdcl_pkg::COUNT_W-1:0]          rank,
   output logic signed [kdcl_pkg::COORD_W-1:0]   cell_low [MAX_DIMS],
   output logic signed [kdcl_pkg::COORD_W-1:0]   cell_high [MAX_DIMS],
   output logic                                  coincident
);

   localparam int ADDR_W = $clog2(MAX_POINTS);
   localparam int NODE_W = $clog2(MAX_POINTS + 2048);
   localparam int STEP_W = $clog2(MAX_POINTS + 1);
   localparam int CW     = kdcl_pkg::COORD_W;
   localparam int NW     = kdcl_pkg::COUNT_W;
   localparam int DW     = kdcl_pkg::DIM_W;

   // configuration
   logic [DW-1:0] dims_used_ff;
   logic [NW-1:0] point_count_ff;

   // root box
   logic signed [CW-1:0] root_low_ff [MAX_DIMS];
   logic signed [CW-1:0] root_high_ff [MAX_DIMS];

   // descent state
   logic signed [CW-1:0] q_ff [MAX_DIMS];
   logic signed [CW-1:0] lo_ff [MAX_DIMS], lo_in [MAX_DIMS];
   logic signed [CW-1:0] hi_ff [MAX_DIMS], hi_in [MAX_DIMS];
   logic                 by_index_ff, by_index_in;
   logic [NODE_W-1:0]    node_ff, node_in;
   logic [STEP_W-1:0]    steps_ff, steps_in;
   logic [NW-1:0]        remaining_ff, remaining_in;
   logic [NW-1:0]        rank_ff, rank_in;
   logic [NW-1:0]        target_ff, target_in;
   logic                 coinc_ff, coinc_in;

   logic [kdcl_pkg::NODE_DATA_W-1:0] rd_data;
   logic [kdcl_pkg::NODE_DATA_W-1:0] wr_data;
   logic                             wr_en;

   logic [DW-1:0]        dcount;
   logic [DW-1:0]        ds;
   logic signed [CW-1:0] xs;
   logic [NW-1:0]        nl;
   logic [NW-1:0]        nl_sat;
   logic signed [CW-1:0] q_sel;
   logic                 halt;
   logic                 coinc_hit;
   logic                 go_left;
   logic                 advance;

   assign wr_en   = cmd.load_node && (32'(node_addr) < MAX_POINTS);
   assign wr_data = {split_dim, split_value, left_count};

   kdcl_ram #(
      .WIDTH (kdcl_pkg::NODE_DATA_W),
      .DEPTH (MAX_POINTS)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (ADDR_W'(node_addr)),
      .wr_data (wr_data),
      .rd_addr (node_in[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   // read data always belongs to slot node_ff[ADDR_W-1:0]
   assign ds = rd_data[kdcl_pkg::NODE_DATA_W-1 -: DW];
   assign xs = rd_data[NW +: CW];
   assign nl = rd_data[NW-1:0];

   always_comb begin
      dcount = (dims_used_ff < DW'(MAX_DIMS)) ? dims_used_ff : DW'(MAX_DIMS);
      nl_sat = (nl > remaining_ff) ? remaining_ff : nl;
      q_sel  = '0;
      for (int d = 0; d < MAX_DIMS; d++) begin
         if (ds == DW'(d)) begin
            q_sel = q_ff[d];
         end
      end
      halt = (remaining_ff <= NW'(1)) || (node_ff >= NODE_W'(MAX_POINTS)) ||
             (steps_ff == STEP_W'(MAX_POINTS));
      coinc_hit   = !halt && (ds >= dcount);
      go_left     = by_index_ff ? (target_ff <= nl_sat) : (q_sel <= xs);
      advance     = cmd.step && !halt && !coinc_hit;
      status.done = halt || coinc_hit;
   end

   always_comb begin
      by_index_in  = by_index_ff;
      node_in      = node_ff;
      steps_in     = steps_ff;
      remaining_in = remaining_ff;
      rank_in      = rank_ff;
      target_in    = target_ff;
      coinc_in     = coinc_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      if (cmd.start) begin
         by_index_in  = (action == kdcl_pkg::ACT_LOCATE_IDX);
         node_in      = '0;
         steps_in     = '0;
         remaining_in = point_count_ff;
         rank_in      = '0;
         target_in    = NW'(query_index) + NW'(1);
         coinc_in     = 1'b0;
         for (int d = 0; d < MAX_DIMS; d++) begin
            lo_in[d] = (DW'(d) < dcount) ? root_low_ff[d] : '0;
            hi_in[d] = (DW'(d) < dcount) ? root_high_ff[d] : '0;
         end
      end else if (cmd.step && coinc_hit) begin
         coinc_in = 1'b1;
      end else if (advance) begin
         steps_in = steps_ff + STEP_W'(1);
         if (go_left) begin
            remaining_in = nl_sat;
            node_in      = node_ff + NODE_W'(1);
            for (int d = 0; d < MAX_DIMS; d++) begin
               if (ds == DW'(d)) begin
                  hi_in[d] = xs;
               end
            end
         end else begin
            rank_in      = rank_ff + nl_sat;
            target_in    = target_ff - nl_sat;
            remaining_in = remaining_ff - nl_sat;
            node_in      = node_ff + NODE_W'(nl_sat);
            for (int d = 0; d < MAX_DIMS; d++) begin
               if (ds == DW'(d)) begin
                  lo_in[d] = xs;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dims_used_ff   <= kdcl_pkg::DIMS_USED_RESET;
         point_count_ff <= kdcl_pkg::POINT_COUNT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            kdcl_pkg::CSR_DIMS_USED:   dims_used_ff   <= csr_wdata[DW-1:0];
            kdcl_pkg::CSR_POINT_COUNT: point_count_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      for (int d = 0; d < MAX_DIMS; d++) begin
         if (cmd.load_bounds && split_dim == DW'(d)) begin
            root_low_ff[d]  <= bound_low;
            root_high_ff[d] <= bound_high;
         end
         if (cmd.start) begin
            q_ff[d] <= query[d];
         end
      end
      by_index_ff  <= by_index_in;
      node_ff      <= node_in;
      steps_ff     <= steps_in;
      remaining_ff <= remaining_in;
      rank_ff      <= rank_in;
      target_ff    <= target_in;
      coinc_ff     <= coinc_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
   end

   assign rank       = rank_ff;
   assign cell_low   = lo_ff;
   assign cell_high  = hi_ff;
   assign coincident = coinc_ff;

endmodule

>>> rtl/kd_tree_cell_locate.sv
// Top level of the kd-tree cell locate block.
//
// Holds an implicit kd-tree in preorder node slots plus a root box, and
// answers point-location and index-location queries with the rank and box
// of the leaf cell reached.
// The req_ channel takes one item a cycle while idle. Load node and load
// bounds items are written in the cycle they are accepted and give no result.
// A locate item runs a descent of one node a cycle: the node table RAM is
// read at the next slot while the current slot's data is compared, and the
// result is shown on the rsp_ channel the cycle after the descent ends; the
// next item can be taken in the cycle after the result is taken.
// One locate item is in flight at a time; req_ready is low from accept until
// the result is taken. A stalled rsp_ready holds the result registers steady.
// csr_ writes take effect at once and must be made while the block is idle.
// Reset returns the controller to idle and sets dims_used to 2 and
// point_count to 1; the node table and root box come up unknown until loaded.
module kd_tree_cell_locate #(
   parameter int MAX_POINTS = 1024,
   parameter int MAX_DIMS   = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [kdcl_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [kdcl_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [kdcl_pkg::ACTION_W-1:0]       req_action,
   input  logic [kdcl_pkg::NADDR_W-1:0]        req_node_addr,
   input  logic [kdcl_pkg::DIM_W-1:0]          req_split_dim,
   input  logic signed [kdcl_pkg::COORD_W-1:0] req_split_value,
   input  logic [kdcl_pkg::COUNT_W-1:0]        req_left_count,
   input  logic signed [kdcl_pkg::COORD_W-1:0] req_bound_low,
   input  logic signed [kdcl_pkg::COORD_W-1:0] req_bound_high,
   input  logic signed [kdcl_pkg::COORD_W-1:0] req_query_x0,
   input  logic signed [kdcl_pkg::COORD_W-1:0] req_query_x1,
   input  logic signed [kdcl_pkg::COORD_W-1:0] req_query_x2,
   input  logic signed [kdcl_pkg::COORD_W-1:0] req_query_x3,
   input  logic [kdcl_pkg::NADDR_W-1:0]        req_query_index,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [kdcl_pkg::COUNT_W-1:0]        rsp_rank,
   output logic signed [kdcl_pkg::COORD_W-1:0] rsp_cell_low_0,
   output logic signed [kdcl_pkg::COORD_W-1:0] rsp_cell_high_0,
   output logic signed [kdcl_pkg::COORD_W-1:0] rsp_cell_low_1,
   output logic signed [kdcl_pkg::COORD_W-1:0] rsp_cell_high_1,
   output logic signed [kdcl_pkg::COORD_W-1:0] rsp_cell_low_2,
   output logic signed [kdcl_pkg::COORD_W-1:0] rsp_cell_high_2,
   output logic signed [kdcl_pkg::COORD_W-1:0] rsp_cell_low_3,
   output logic signed [kdcl_pkg::COORD_W-1:0] rsp_cell_high_3,
   output logic                                rsp_coincident
);

   kdcl_pkg::cmd_type    cmd;
   kdcl_pkg::status_type status;
   kdcl_pkg::action_type action;

   logic signed [kdcl_pkg::COORD_W-1:0] query     [kdcl_pkg::DIM_SLOTS];
   logic signed [kdcl_pkg::COORD_W-1:0] cell_low  [MAX_DIMS];
   logic signed [kdcl_pkg::COORD_W-1:0] cell_high [MAX_DIMS];
   logic signed [kdcl_pkg::COORD_W-1:0] low_all   [kdcl_pkg::DIM_SLOTS];
   logic signed [kdcl_pkg::COORD_W-1:0] high_all  [kdcl_pkg::DIM_SLOTS];

   assign action   = kdcl_pkg::action_type'(req_action);
   assign query[0] = req_query_x0;
   assign query[1] = req_query_x1;
   assign query[2] = req_query_x2;
   assign query[3] = req_query_x3;

   kdcl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (action),
      .req_ready  (req_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .cmd        (cmd),
      .status     (status)
   );

   kdcl_dpath #(
      .MAX_POINTS (MAX_POINTS),
      .MAX_DIMS   (MAX_DIMS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .csr_we      (csr_we),
      .csr_index   (kdcl_pkg::csr_index_type'(csr_index)),
      .csr_wdata   (csr_wdata),
      .action      (action),
      .node_addr   (req_node_addr),
      .split_dim   (req_split_dim),
      .split_value (req_split_value),
      .left_count  (req_left_count),
      .bound_low   (req_bound_low),
      .bound_high  (req_bound_high),
      .query       (query),
      .query_index (req_query_index),
      .rank        (rsp_rank),
      .cell_low    (cell_low),
      .cell_high   (cell_high),
      .coincident  (rsp_coincident)
   );

   // dimensions beyond the built ones read as zero
   for (genvar d = 0; d < kdcl_pkg::DIM_SLOTS; d++) begin : g_cell
      if (d < MAX_DIMS) begin : g_used
         assign low_all[d]  = cell_low[d];
         assign high_all[d] = cell_high[d];
      end else begin : g_unused
         assign low_all[d]  = '0;
         assign high_all[d] = '0;
      end
   end

   assign rsp_cell_low_0  = low_all[0];
   assign rsp_cell_high_0 = high_all[0];
   assign rsp_cell_low_1  = low_all[1];
   assign rsp_cell_high_1 = high_all[1];
   assign rsp_cell_low_2  = low_all[2];
   assign rsp_cell_high_2 = high_all[2];
   assign rsp_cell_low_3  = low_all[3];
   assign rsp_cell_high_3 = high_all[3];

endmodule

>>> verif/kd_tree_cell_locate_tb.sv
// Self-checking testbench for the kd-tree cell locate block: tree loads, point and index queries.
`timescale 1ns / 1ps

module testbench;

   localparam int NODE_SLOTS    = 1024;
   // The table preload sends 1024 items; the random phases send at least RANDOM_ITEMS more.
   localparam int RANDOM_ITEMS  = 480;
   localparam int SETTLE_CYCLES = 16;
   // Worst case: every locate runs the full 1024-step descent under heavy stalls.
   localparam int CYCLE_LIMIT   = 10_000_000;
   localparam logic [kdcl_pkg::COORD_W-1:0] COORD_MIN = 32'h8000_0000;
   localparam logic [kdcl_pkg::COORD_W-1:0] COORD_MAX = 32'h7fff_ffff;

   typedef struct packed {
      kdcl_pkg::action_type                 action;
      logic [kdcl_pkg::NADDR_W-1:0]         node_addr;
      logic [kdcl_pkg::DIM_W-1:0]           split_dim;
      logic [kdcl_pkg::COORD_W-1:0]         split_value;
      logic [kdcl_pkg::COUNT_W-1:0]         left_count;
      logic [kdcl_pkg::COORD_W-1:0]         bound_low;
      logic [kdcl_pkg::COORD_W-1:0]         bound_high;
      logic [3:0][kdcl_pkg::COORD_W-1:0]    query_x;
      logic [kdcl_pkg::NADDR_W-1:0]         query_index;
   } req_item_type;

   typedef struct packed {
      logic [kdcl_pkg::COUNT_W-1:0]         rank;
      logic [3:0][kdcl_pkg::COORD_W-1:0]    lo;
      logic [3:0][kdcl_pkg::COORD_W-1:0]    hi;
      logic                                 coincident;
   } cell_box_type;

   logic clock;
   logic reset;
   logic csr_we;
   kdcl_pkg::csr_index_type csr_index;
   logic [kdcl_pkg::CSR_DATA_W-1:0] csr_wdata;
   logic req_valid;
   logic req_ready;
   logic [kdcl_pkg::ACTION_W-1:0] req_action;
   logic [kdcl_pkg::NADDR_W-1:0] req_node_addr;
   logic [kdcl_pkg::DIM_W-1:0] req_split_dim;
   logic signed [kdcl_pkg::COORD_W-1:0] req_split_value;
   logic [kdcl_pkg::COUNT_W-1:0] req_left_count;
   logic signed [kdcl_pkg::COORD_W-1:0] req_bound_low;
   logic signed [kdcl_pkg::COORD_W-1:0] req_bound_high;
   logic signed [kdcl_pkg::COORD_W-1:0] req_query_x0;
   logic signed [kdcl_pkg::COORD_W-1:0] req_query_x1;
   logic signed [kdcl_pkg::COORD_W-1:0] req_query_x2;
   logic signed [kdcl_pkg::COORD_W-1:0] req_query_x3;
   logic [kdcl_pkg::NADDR_W-1:0] req_query_index;
   logic rsp_valid;
   logic rsp_ready;
   logic [kdcl_pkg::COUNT_W-1:0] rsp_rank;
   logic signed [kdcl_pkg::COORD_W-1:0] rsp_cell_low_0;
   logic signed [kdcl_pkg::COORD_W-1:0] rsp_cell_high_0;
   logic signed [kdcl_pkg::COORD_W-1:0] rsp_cell_low_1;
   logic signed [kdcl_pkg::COORD_W-1:0] rsp_cell_high_1;
   logic signed [kdcl_pkg::COORD_W-1:0] rsp_cell_low_2;
   logic signed [kdcl_pkg::COORD_W-1:0] rsp_cell_high_2;
   logic signed [kdcl_pkg::COORD_W-1:0] rsp_cell_low_3;
   logic signed [kdcl_pkg::COORD_W-1:0] rsp_cell_high_3;
   logic rsp_coincident;

   // Shadow copy of the block's tables and registers.
   logic [kdcl_pkg::DIM_W-1:0]          node_dim   [NODE_SLOTS];
   logic signed [kdcl_pkg::COORD_W-1:0] node_split [NODE_SLOTS];
   logic [kdcl_pkg::COUNT_W-1:0]        node_left  [NODE_SLOTS];
   logic signed [kdcl_pkg::COORD_W-1:0] root_lo    [kdcl_pkg::DIM_SLOTS];
   logic signed [kdcl_pkg::COORD_W-1:0] root_hi    [kdcl_pkg::DIM_SLOTS];
   logic [kdcl_pkg::DIM_W-1:0]          cfg_dims;
   logic [kdcl_pkg::COUNT_W-1:0]        cfg_points;

   cell_box_type pending_cells[$];
   int error_count = 0;
   int item_count = 0;
   int cycle_count = 0;
   int idle_pct = 0;
   int stall_pct = 0;

   kd_tree_cell_locate uut (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_ready(req_ready), .req_action(req_action),
      .req_node_addr(req_node_addr), .req_split_dim(req_split_dim),
      .req_split_value(req_split_value), .req_left_count(req_left_count),
      .req_bound_low(req_bound_low), .req_bound_high(req_bound_high),
      .req_query_x0(req_query_x0), .req_query_x1(req_query_x1),
      .req_query_x2(req_query_x2), .req_query_x3(req_query_x3),
      .req_query_index(req_query_index),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_rank(rsp_rank),
      .rsp_cell_low_0(rsp_cell_low_0), .rsp_cell_high_0(rsp_cell_high_0),
      .rsp_cell_low_1(rsp_cell_low_1), .rsp_cell_high_1(rsp_cell_high_1),
      .rsp_cell_low_2(rsp_cell_low_2), .rsp_cell_high_2(rsp_cell_high_2),
      .rsp_cell_low_3(rsp_cell_low_3), .rsp_cell_high_3(rsp_cell_high_3),
      .rsp_coincident(rsp_coincident)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   // Receiver: stall rsp_ready at random per cycle.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ready = ($urandom_range(0, 99) >= stall_pct);
      end
   end

   function automatic cell_box_type locate_cell(input req_item_type it);
      cell_box_type res;
      int unsigned dcount, node, remaining, rank, target, steps, ds, nl;
      bit go_left;
      dcount = (cfg_dims < kdcl_pkg::DIM_SLOTS) ? cfg_dims : kdcl_pkg::DIM_SLOTS;
      res = '0;
      for (int d = 0; d < kdcl_pkg::DIM_SLOTS; d++) begin
         res.lo[d] = (d < dcount) ? root_lo[d] : '0;
         res.hi[d] = (d < dcount) ? root_hi[d] : '0;
      end
      node = 0;
      rank = 0;
      steps = 0;
      target = it.query_index + 1;
      remaining = cfg_points;
      while (remaining > 1 && node < NODE_SLOTS && steps < NODE_SLOTS) begin
         ds = node_dim[node];
         nl = node_left[node];
         steps++;
         if (ds >= dcount) begin
            res.coincident = 1'b1;
            break;
         end
         if (nl > remaining) nl = remaining;
         if (it.action == kdcl_pkg::ACT_LOCATE_PT)
            go_left = ($signed(it.query_x[ds]) <= node_split[node]);
         else
            go_left = (target <= nl);
         if (go_left) begin
            res.hi[ds] = node_split[node];
            remaining = nl;
            node = node + 1;
         end else begin
            res.lo[ds] = node_split[node];
            rank = rank + nl;
            if (it.action == kdcl_pkg::ACT_LOCATE_IDX) target = target - nl;
            remaining = remaining - nl;
            node = node + nl;
         end
      end
      res.rank = kdcl_pkg::COUNT_W'(rank);
      return res;
   endfunction

   function automatic req_item_type random_item(input kdcl_pkg::action_type act);
      req_item_type it;
      it.action      = act;
      it.node_addr   = kdcl_pkg::NADDR_W'($urandom);
      it.split_dim   = kdcl_pkg::DIM_W'($urandom);
      it.split_value = $urandom;
      it.left_count  = kdcl_pkg::COUNT_W'($urandom);
      it.bound_low   = $urandom;
      it.bound_high  = $urandom;
      for (int d = 0; d < 4; d++) it.query_x[d] = $urandom;
      it.query_index = kdcl_pkg::NADDR_W'($urandom);
      return it;
   endfunction

   task automatic report_error(input string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      error_count++;
   endtask

   always @(posedge clock) begin : check_results
      cell_box_type want;
      logic [3:0][kdcl_pkg::COORD_W-1:0] got_lo, got_hi;
      if (!reset && rsp_valid && rsp_ready) begin
         got_lo = {rsp_cell_low_3, rsp_cell_low_2, rsp_cell_low_1, rsp_cell_low_0};
         got_hi = {rsp_cell_high_3, rsp_cell_high_2, rsp_cell_high_1, rsp_cell_high_0};
         if (pending_cells.size() == 0) begin
            report_error("result item with no locate pending");
         end else begin
            want = pending_cells.pop_front();
            if (rsp_rank !== want.rank)
               report_error($sformatf("rank got %0d want %0d", rsp_rank, want.rank));
            for (int d = 0; d < kdcl_pkg::DIM_SLOTS; d++) begin
               if (got_lo[d] !== want.lo[d])
                  report_error($sformatf("cell_low_%0d got %h want %h",
                                         d, got_lo[d], want.lo[d]));
               if (got_hi[d] !== want.hi[d])
                  report_error($sformatf("cell_high_%0d got %h want %h",
                                         d, got_hi[d], want.hi[d]));
            end
            if (rsp_coincident !== want.coincident)
               report_error($sformatf("coincident got %b want %b",
                                      rsp_coincident, want.coincident));
         end
      end
   end

   // Send one item; valid stays high after accept until the next call or drain.
   task automatic send_item(input req_item_type it);
      int gap;
      gap = 0;
      while (gap < 20 && $urandom_range(0, 99) < idle_pct) gap++;
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_action      = it.action;
      req_node_addr   = it.node_addr;
      req_split_dim   = it.split_dim;
      req_split_value = it.split_value;
      req_left_count  = it.left_count;
      req_bound_low   = it.bound_low;
      req_bound_high  = it.bound_high;
      req_query_x0    = it.query_x[0];
      req_query_x1    = it.query_x[1];
      req_query_x2    = it.query_x[2];
      req_query_x3    = it.query_x[3];
      req_query_index = it.query_index;
      req_valid       = 1'b1;
      do @(posedge clock); while (!req_ready);
      case (it.action)
         kdcl_pkg::ACT_LOAD_NODE: begin
            node_dim[it.node_addr]   = it.split_dim;
            node_split[it.node_addr] = it.split_value;
            node_left[it.node_addr]  = it.left_count;
         end
         kdcl_pkg::ACT_LOAD_BOUNDS: begin
            if (it.split_dim < kdcl_pkg::DIM_SLOTS) begin
               root_lo[it.split_dim] = it.bound_low;
               root_hi[it.split_dim] = it.bound_high;
            end
         end
         default: pending_cells = {pending_cells, locate_cell(it)};
      endcase
      if (!(it.action == kdcl_pkg::ACT_LOAD_BOUNDS && it.split_dim >= kdcl_pkg::DIM_SLOTS))
         item_count++;
   endtask

   // Drop valid, wait for all results, then let the block settle.
   task automatic wait_idle();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_cells.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input kdcl_pkg::csr_index_type idx,
                            input logic [kdcl_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      if (idx == kdcl_pkg::CSR_DIMS_USED) cfg_dims = value[kdcl_pkg::DIM_W-1:0];
      else cfg_points = value;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic set_config(input int dims, input int points);
      logic [kdcl_pkg::CSR_DATA_W-1:0] dims_word;
      wait_idle();
      dims_word = kdcl_pkg::CSR_DATA_W'($urandom);
      dims_word[kdcl_pkg::DIM_W-1:0] = kdcl_pkg::DIM_W'(dims);
      write_csr(kdcl_pkg::CSR_DIMS_USED, dims_word);
      write_csr(kdcl_pkg::CSR_POINT_COUNT, kdcl_pkg::CSR_DATA_W'(points));
   endtask

   task automatic set_idling(input int mode);
      case (mode)
         0: begin idle_pct = 0;  stall_pct = 0;  end
         1: begin idle_pct = 54; stall_pct = 0;  end
         2: begin idle_pct = 0;  stall_pct = 54; end
         default: begin idle_pct = 33; stall_pct = 33; end
      endcase
   endtask

   task automatic send_node(input int addr, input int dim,
                            input logic [kdcl_pkg::COORD_W-1:0] value, input int nl);
      req_item_type it;
      it = random_item(kdcl_pkg::ACT_LOAD_NODE);
      it.node_addr   = kdcl_pkg::NADDR_W'(addr);
      it.split_dim   = kdcl_pkg::DIM_W'(dim);
      it.split_value = value;
      it.left_count  = kdcl_pkg::COUNT_W'(nl);
      send_item(it);
   endtask

   task automatic send_bounds(input int dim, input logic [kdcl_pkg::COORD_W-1:0] low,
                              input logic [kdcl_pkg::COORD_W-1:0] high);
      req_item_type it;
      it = random_item(kdcl_pkg::ACT_LOAD_BOUNDS);
      it.split_dim  = kdcl_pkg::DIM_W'(dim);
      it.bound_low  = low;
      it.bound_high = high;
      send_item(it);
   endtask

   task automatic send_point(input logic [kdcl_pkg::COORD_W-1:0] x0,
                             input logic [kdcl_pkg::COORD_W-1:0] x1,
                             input logic [kdcl_pkg::COORD_W-1:0] x2,
                             input logic [kdcl_pkg::COORD_W-1:0] x3);
      req_item_type it;
      it = random_item(kdcl_pkg::ACT_LOCATE_PT);
      it.query_x = {x3, x2, x1, x0};
      send_item(it);
   endtask

   task automatic send_index(input int idx);
      req_item_type it;
      it = random_item(kdcl_pkg::ACT_LOCATE_IDX);
      it.query_index = kdcl_pkg::NADDR_W'(idx);
      send_item(it);
   endtask

   function automatic int pick_dim(input int dcount);
      if (dcount == 0) return $urandom_range(0, 7);
      if ($urandom_range(0, 24) == 0) return $urandom_range(dcount, 7);
      return $urandom_range(0, dcount - 1);
   endfunction

   // Preorder load of a subtree of pts points rooted at slot base.
   task automatic load_subtree(input int base, input int pts, input bit balanced,
                               input int depth, input int dcount);
      int dim, nl, sel;
      if (pts <= 1 || base >= NODE_SLOTS) return;
      if (balanced) begin
         dim = depth % kdcl_pkg::DIM_SLOTS;
         nl  = pts / 2;
      end else begin
         dim = pick_dim(dcount);
         sel = $urandom_range(0, 149);
         if (sel == 0) nl = 0;
         else if (sel == 1) nl = $urandom_range(pts, 2047);
         else nl = $urandom_range(1, pts - 1);
      end
      send_node(base, dim, $urandom, nl);
      // Broken counts leave the children as they were.
      if (nl >= 1 && nl < pts) begin
         load_subtree(base + 1, nl, balanced, depth + 1, dcount);
         load_subtree(base + nl, pts - nl, balanced, depth + 1, dcount);
      end
   endtask

   function automatic logic [kdcl_pkg::COORD_W-1:0] pick_coord(input int maxslot);
      case ($urandom_range(0, 9))
         0: return COORD_MIN;
         1: return COORD_MAX;
         2, 3, 4, 5: return node_split[$urandom_range(0, maxslot)] + $urandom_range(0, 2) - 1;
         default: return $urandom;
      endcase
   endfunction

   // Fill every node slot so no descent ever reads an unwritten entry.
   task automatic test_table_preload();
      set_idling(0);
      load_subtree(0, NODE_SLOTS, 1'b1, 0, kdcl_pkg::DIM_SLOTS);
      send_node(NODE_SLOTS - 1, $urandom_range(0, 3), $urandom, $urandom_range(0, 2047));
   endtask

   task automatic test_reset_config();
      send_bounds(0, COORD_MIN, COORD_MAX);
      send_bounds(1, COORD_MAX, COORD_MIN);
      send_bounds(2, $urandom, $urandom);
      send_bounds(3, $urandom, $urandom);
      // Out-of-range dimension: ignored by the block.
      send_bounds(4, $urandom, $urandom);
      send_bounds(7, $urandom, $urandom);
      send_point(COORD_MIN, COORD_MAX, $urandom, $urandom);
      send_index(0);
   endtask

   task automatic test_full_tree();
      set_config(4, 1024);
      send_point(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
      send_point(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
      send_index(0);
      send_index(1023);
      // More points than slots: descent runs off the end of the table.
      set_config(4, 2047);
      send_index(1023);
      send_point(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
      set_config(3, 0);
      send_point($urandom, $urandom, $urandom, $urandom);
   endtask

   task automatic test_special_nodes();
      set_config(3, 6);
      send_node(0, 3, $urandom, 3);
      send_point($urandom, $urandom, $urandom, $urandom);
      send_node(0, 7, $urandom, 3);
      send_index(2);
      // Oversized left count saturates; equal coordinate goes left.
      send_node(0, 0, 32'd0, 2047);
      send_point(32'd0, $urandom, $urandom, $urandom);
      // Zero left count pins the descent to the root until the step limit.
      send_node(0, 1, $urandom, 0);
      send_index(0);
      send_node(0, 0, $urandom, 3);
      send_index(1023);
      set_config(0, 6);
      send_point($urandom, $urandom, $urandom, $urandom);
      set_config(7, 6);
      send_point($urandom, $urandom, $urandom, $urandom);
   endtask

   task automatic run_random_phase(input int phase);
      int dims, points, dcount, maxslot, sel, nq, hi_idx;
      req_item_type it;
      sel = $urandom_range(0, 19);
      if (sel == 0) dims = 0;
      else if (sel == 1) dims = $urandom_range(5, 7);
      else dims = $urandom_range(1, 4);
      sel = $urandom_range(0, 29);
      if (sel == 0) points = $urandom_range(0, 1);
      else if (sel == 1) points = $urandom_range(200, 1024);
      else if (sel == 2) points = $urandom_range(1025, 2047);
      else points = $urandom_range(2, 48);
      set_config(dims, points);
      set_idling(phase % 4);
      dcount = (dims < kdcl_pkg::DIM_SLOTS) ? dims : kdcl_pkg::DIM_SLOTS;
      for (int d = 0; d < kdcl_pkg::DIM_SLOTS; d++) send_bounds(d, $urandom, $urandom);
      if (points <= NODE_SLOTS) load_subtree(0, points, 1'b0, 0, dcount);
      maxslot = (points >= 2) ? ((points - 2 < NODE_SLOTS) ? points - 2 : NODE_SLOTS - 1) : 0;
      hi_idx  = (points >= 1) ? ((points - 1 < NODE_SLOTS) ? points - 1 : NODE_SLOTS - 1) : 0;
      nq = $urandom_range(20, 40);
      repeat (nq) begin
         sel = $urandom_range(0, 99);
         if (sel < 45) begin
            send_point(pick_coord(maxslot), pick_coord(maxslot),
                       pick_coord(maxslot), pick_coord(maxslot));
         end else if (sel < 90) begin
            if ($urandom_range(0, 9) == 0) send_index($urandom_range(0, 1023));
            else send_index($urandom_range(0, hi_idx));
         end else if (sel < 95) begin
            it = random_item(kdcl_pkg::ACT_LOAD_NODE);
            send_item(it);
         end else begin
            it = random_item(kdcl_pkg::ACT_LOAD_BOUNDS);
            send_item(it);
         end
         // Hold off now and then until every result is back.
         if ($urandom_range(0, 59) == 0) wait_idle();
      end
   endtask

   task automatic test_random();
      int start_count, phase;
      start_count = item_count;
      phase = 0;
      while (item_count - start_count < RANDOM_ITEMS) begin
         run_random_phase(phase);
         phase++;
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = kdcl_pkg::CSR_DIMS_USED;
      csr_wdata = '0;
      req_valid = 1'b0;
      req_action = kdcl_pkg::ACT_LOAD_NODE;
      req_node_addr = '0;
      req_split_dim = '0;
      req_split_value = '0;
      req_left_count = '0;
      req_bound_low = '0;
      req_bound_high = '0;
      req_query_x0 = '0;
      req_query_x1 = '0;
      req_query_x2 = '0;
      req_query_x3 = '0;
      req_query_index = '0;
      cfg_dims = kdcl_pkg::DIMS_USED_RESET;
      cfg_points = kdcl_pkg::POINT_COUNT_RESET;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_table_preload();
      test_reset_config();
      test_full_tree();
      test_special_nodes();
      test_random();

      wait_idle();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (pending_cells.size() != 0)
         report_error($sformatf("%0d locate results never arrived", pending_cells.size()));
      if (error_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

>>> files.f
rtl/kdcl_pkg.sv
rtl/kdcl_ram.sv
rtl/kdcl_ctrl.sv
rtl/kdcl_dpath.sv
rtl/kd_tree_cell_locate.sv
verif/kd_tree_cell_locate_tb.sv
